// ----- design/via_pkg.sv -----
package via_pkg;
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_PINS  = 2'd3
  } via_op_t;

  localparam logic [3:0] R_ORB = 4'd0, R_ORA = 4'd1, R_DDRB = 4'd2, R_DDRA = 4'd3,
    R_T1CL = 4'd4, R_T1CH = 4'd5, R_T1LL = 4'd6, R_T1LH = 4'd7, R_T2CL = 4'd8,
    R_T2CH = 4'd9, R_SR = 4'd10, R_ACR = 4'd11, R_PCR = 4'd12, R_IFR = 4'd13,
    R_IER = 4'd14, R_ORA_NH = 4'd15;

  localparam logic [7:0] F_CA2 = 8'h01, F_CA1 = 8'h02, F_SR = 8'h04, F_CB2 = 8'h08,
    F_CB1 = 8'h10, F_T2 = 8'h20, F_T1 = 8'h40, F_ANY = 8'h80;

  localparam logic [2:0] C2_HSK = 3'd4, C2_PULSE = 3'd5, C2_LOW = 3'd6;
endpackage

// ----- design/versatile_interface_adapter.sv -----
// Versatile interface adapter: two 8-bit ports with direction registers, two
// 16-bit timers, interrupt flag/enable registers, CA1/CA2/CB1/CB2 control
// lines and a stored shift byte. Each request is a register read, a register
// write, one timer tick or a pin update, selected by in_tuser. Every request
// yields exactly one result with read data, the IRQ level and the pin levels.
// One request is taken per clock unless stalled: the whole update is one pass
// of logic from the input register into the state and result registers, and a
// full result register still accepts when the consumer takes it in the same cycle.
module versatile_interface_adapter
  import via_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] reg_addr, [11:4] write_data, [19:12] port_a_pins, [27:20] port_b_pins,
  // [28] ca1_in, [29] ca2_in, [30] cb1_in, [31] cb2_in
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,     // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [8] irq_level, [16:9] port_a_out, [24:17] port_b_out,
  // [25] ca2_level_out, [26] cb2_level_out, [31:27] zero
  output logic [31:0] out_tdata
);
  // input register
  logic        iv_r;
  logic [31:0] id_r;
  logic [1:0]  iu_r;
  logic        ov_r;
  logic [26:0] od_r;

  logic work;
  assign work      = iv_r && (!ov_r || out_tready);
  assign in_tready = !iv_r || work;
  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, od_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (in_tready) iv_r <= in_tvalid;
      if (work) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    if (in_tready && in_tvalid) begin
      id_r <= in_tdata;
      iu_r <= in_tuser;
    end
  end

  // architectural state
  logic [15:0] t1c_r, t1l_r, t2c_r, t2l_r, t1p_r;
  logic [7:0]  t2p_r, ifr_r, acr_r, pcr_r, sr_r;
  logic [6:0]  ier_r, idl_r;
  logic        t1tg_r, t2f_r, irq_r, pb6_r;
  logic [7:0]  ora_r, orb_r, ddra_r, ddrb_r, ina_r, inb_r;
  logic [3:0]  lvl_r, edg_r;
  logic [1:0]  c2o_r;

  logic [15:0] t1c, t1l, t2c, t2l, t1p;
  logic [7:0]  t2p, ifr, acr, pcr, sr, ora, orb, ddra, ddrb, ina, inb, rd, pbv;
  logic [6:0]  ier, idl;
  logic        t1tg, t2f, irq, pb6, pb6now, act;
  logic [3:0]  lvl, edg;
  logic [1:0]  c2o;
  logic [2:0]  ma, mb;
  logic [7:0]  msk;
  logic [3:0]  ad;
  logic [7:0]  wd;

  function automatic logic [7:0] pl(input logic [7:0] o, input logic [7:0] d,
                                    input logic [7:0] i);
    return (o & d) | (i & ~d);
  endfunction

  always_comb begin
    t1c = t1c_r; t1l = t1l_r; t2c = t2c_r; t2l = t2l_r; t1p = t1p_r; t2p = t2p_r;
    ifr = ifr_r; ier = ier_r; idl = idl_r; acr = acr_r; pcr = pcr_r; sr = sr_r;
    t1tg = t1tg_r; t2f = t2f_r; irq = irq_r; pb6 = pb6_r;
    ora = ora_r; orb = orb_r; ddra = ddra_r; ddrb = ddrb_r; ina = ina_r; inb = inb_r;
    lvl = lvl_r; edg = edg_r; c2o = c2o_r;
    rd = 8'd0; msk = 8'd0; pb6now = 1'b0;
    ad = id_r[3:0]; wd = id_r[11:4];
    ma = pcr_r[3:1]; mb = pcr_r[7:5];
    pbv = pl(orb_r, ddrb_r, inb_r);
    if (acr_r[7]) pbv[7] = t1tg_r;

    case (via_op_t'(iu_r))
      OP_READ: begin
        case (ad)
          R_ORB: begin
            rd = acr_r[1] ? inb_r : pbv;
            msk = F_CB1 | ((mb < C2_HSK && mb[0]) ? 8'd0 : F_CB2);
          end
          R_ORA, R_ORA_NH: begin
            rd = acr_r[0] ? ina_r : pl(ora_r, ddra_r, ina_r);
            if (ad == R_ORA) begin
              msk = F_CA1 | ((ma < C2_HSK && ma[0]) ? 8'd0 : F_CA2);
              if (ma == C2_HSK || ma == C2_PULSE) c2o[0] = 1'b0;
            end
          end
          R_DDRB: rd = ddrb_r;
          R_DDRA: rd = ddra_r;
          R_T1CL: begin rd = t1c_r[7:0]; msk = F_T1; end
          R_T1CH: rd = t1c_r[15:8];
          R_T1LL: rd = t1l_r[7:0];
          R_T1LH: rd = t1l_r[15:8];
          R_T2CL: begin rd = t2c_r[7:0]; msk = F_T2; end
          R_T2CH: rd = t2c_r[15:8];
          R_SR: begin rd = sr_r; msk = F_SR; end
          R_ACR: rd = acr_r;
          R_PCR: rd = pcr_r;
          R_IFR: rd = ifr_r;
          default: rd = {1'b1, ier_r};
        endcase
      end
      OP_WRITE: begin
        case (ad)
          R_ORB: begin
            orb = wd;
            msk = F_CB1 | ((mb < C2_HSK && mb[0]) ? 8'd0 : F_CB2);
            if (mb == C2_HSK || mb == C2_PULSE) c2o[1] = 1'b0;
          end
          R_ORA: begin
            ora = wd;
            msk = F_CA1 | ((ma < C2_HSK && ma[0]) ? 8'd0 : F_CA2);
            if (ma == C2_HSK || ma == C2_PULSE) c2o[0] = 1'b0;
          end
          R_DDRB: ddrb = wd;
          R_DDRA: ddra = wd;
          R_T1CL, R_T1LL: t1l[7:0] = wd;
          R_T1CH: begin
            t1l[15:8] = wd; t1c = {wd, t1l_r[7:0]};
            if (!acr_r[7]) t1tg = 1'b0;
            msk = F_T1; t1p[7:0] = 8'h04;
          end
          R_T1LH: begin t1l[15:8] = wd; msk = F_T1; end
          R_T2CL: t2l[7:0] = wd;
          R_T2CH: begin
            t2l[15:8] = wd; t2c = {wd, t2l_r[7:0]}; t2f = 1'b0;
            msk = F_T2; t2p = 8'h04;
          end
          R_SR: begin sr = wd; msk = F_SR; end
          R_ACR: begin acr = wd; if (!wd[5]) t2p[0] = 1'b0; end
          R_PCR: begin
            pcr = wd;
            if (wd[3:1] >= C2_LOW) c2o[0] = wd[1];
            if (wd[7:5] >= C2_LOW) c2o[1] = wd[5];
          end
          R_IFR: msk = wd[7] ? 8'h7F : wd;
          R_IER: ier = wd[7] ? (ier_r | wd[6:0]) : (ier_r & ~wd[6:0]);
          default: ora = wd;
        endcase
      end
      OP_TICK: begin
        if (ma == C2_PULSE) c2o[0] = 1'b1;
        if (mb == C2_PULSE) c2o[1] = 1'b1;
        if (edg_r[0]) begin ifr = ifr | F_CA1; if (ma == C2_HSK) c2o[0] = 1'b1; end
        if (edg_r[1] && ma < C2_HSK) ifr = ifr | F_CA2;
        if (edg_r[2]) begin ifr = ifr | F_CB1; if (mb == C2_HSK) c2o[1] = 1'b1; end
        if (edg_r[3] && mb < C2_HSK) ifr = ifr | F_CB2;
        edg = 4'd0;
        pb6now = pbv[6];
        pb6 = pb6now;
        if (t1p_r[0]) t1c = t1c - 16'd1;
        if (t1c == 16'hFFFF) begin
          if (acr_r[6]) begin t1tg = ~t1tg; ifr = ifr | F_T1; end
          else if (!t1tg) begin ifr = ifr | F_T1; t1tg = 1'b1; end
          t1p[9] = 1'b1;
        end
        if (t1p[8]) t1c = t1l_r;
        if (acr_r[5]) begin
          if (pb6_r && !pb6now) t2c = t2c - 16'd1;
        end else if (t2p_r[0]) t2c = t2c - 16'd1;
        if (t2c == 16'hFFFF && !t2f) begin ifr = ifr | F_T2; t2f = 1'b1; end
        if (idl_r[0]) begin ifr = ifr | F_ANY; irq = 1'b1; end
        t1p[2] = 1'b1;
        t2p[2] = 1'b1;
        if ((ifr[6:0] & ier_r) != 7'd0) idl[1] = 1'b1;
        t1p = (t1p >> 1) & 16'h7F7F;
        t2p = (t2p >> 1) & 8'h7F;
        idl = (idl >> 1) & 7'h7F;
      end
      default: begin
        ina = (ina_r & ddra_r) | (id_r[19:12] & ~ddra_r);
        inb = (inb_r & ddrb_r) | (id_r[27:20] & ~ddrb_r);
        lvl = id_r[31:28];
        edg[0] = (lvl_r[0] != lvl[0]) && (lvl[0] == pcr_r[0]);
        if (ma < C2_HSK) edg[1] = (lvl_r[1] != lvl[1]) && (lvl[1] == ma[1]);
        edg[2] = (lvl_r[2] != lvl[2]) && (lvl[2] == pcr_r[4]);
        if (mb < C2_HSK) edg[3] = (lvl_r[3] != lvl[3]) && (lvl[3] == mb[1]);
      end
    endcase

    // flag clearing from access side effects
    if (msk != 8'd0) begin
      ifr = ifr & ~msk;
      if ((ifr[6:0] & ier) == 7'd0) begin ifr[7] = 1'b0; idl = 7'd0; end
    end
    // refresh on every request except pin updates
    if (via_op_t'(iu_r) != OP_PINS) begin
      act = (ifr[6:0] & ier) != 7'd0;
      ifr[7] = act;
      irq = act;
    end else begin
      act = 1'b0;
    end
  end

  logic [7:0] pbo;
  always_comb begin
    pbo = pl(orb, ddrb, inb);
    if (acr[7]) pbo[7] = t1tg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1c_r <= 16'd0; t1l_r <= 16'hFFFF; t2c_r <= 16'd0; t2l_r <= 16'hFFFF;
      t1p_r <= 16'd0; t2p_r <= 8'd0; t1tg_r <= 1'b0; t2f_r <= 1'b0;
      ifr_r <= 8'd0; ier_r <= 7'd0; acr_r <= 8'd0; pcr_r <= 8'd0; sr_r <= 8'd0;
      ora_r <= 8'd0; orb_r <= 8'd0; ddra_r <= 8'd0; ddrb_r <= 8'd0;
      ina_r <= 8'hFF; inb_r <= 8'hFF; lvl_r <= 4'd0; edg_r <= 4'd0;
      c2o_r <= 2'b11; irq_r <= 1'b0; idl_r <= 7'd0; pb6_r <= 1'b1;
    end else if (work) begin
      t1c_r <= t1c; t1l_r <= t1l; t2c_r <= t2c; t2l_r <= t2l;
      t1p_r <= t1p; t2p_r <= t2p; t1tg_r <= t1tg; t2f_r <= t2f;
      ifr_r <= ifr; ier_r <= ier; acr_r <= acr; pcr_r <= pcr; sr_r <= sr;
      ora_r <= ora; orb_r <= orb; ddra_r <= ddra; ddrb_r <= ddrb;
      ina_r <= ina; inb_r <= inb; lvl_r <= lvl; edg_r <= edg;
      c2o_r <= c2o; irq_r <= irq; idl_r <= idl; pb6_r <= pb6;
    end
    if (work) od_r <= {c2o[1], c2o[0], pbo, pl(ora, ddra, ina), irq, rd};
  end
endmodule

// ----- verif/versatile_interface_adapter_check.sv -----
`timescale 1ns / 100ps

// Watches both channels, models the adapter per accepted request and compares
// every result field with the oldest predicted one.
module versatile_interface_adapter_check
  import via_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic       cb2;
    logic       ca2;
    logic [7:0] pb;
    logic [7:0] pa;
    logic       irq;
    logic [7:0] rd;
  } via_result_t;

  via_result_t result_q[$];

  logic [15:0] t1_cnt, t1_latch, t2_cnt, t2_latch, t1_pipe;
  logic [7:0]  t2_pipe, ifr, ier, acr, pcr, sr_byte;
  logic [7:0]  orx[2], ddr[2], irx[2];
  logic [3:0]  lines, edges;
  logic [1:0]  c2_lvl;
  logic [7:0]  irq_dly;
  logic        t1_tog, t2_done, irq_now, last_pb6;

  function automatic logic [7:0] pin_level(int p);
    return (orx[p] & ddr[p]) | (irx[p] & ~ddr[p]);
  endfunction

  function automatic logic [7:0] pb_level();
    logic [7:0] v;
    v = pin_level(1);
    if (acr[7]) v[7] = t1_tog;
    return v;
  endfunction

  function automatic logic [2:0] c2_mode(int p);
    return p ? pcr[7:5] : pcr[3:1];
  endfunction

  function automatic bit c2_is_input(int p);
    return c2_mode(p) < C2_HSK;
  endfunction

  task automatic drop_flags(logic [7:0] bits);
    ifr &= ~bits;
    if ((ifr & ier & 8'h7f) == 0) begin
      ifr &= 8'h7f;
      irq_dly = 0;
    end
  endtask

  task automatic irq_refresh();
    irq_now = (ifr & ier & 8'h7f) != 0;
    ifr[7] = irq_now;
  endtask

  task automatic drop_port_flags(int p);
    logic [7:0] m;
    logic [2:0] mode;
    mode = c2_mode(p);
    m = p ? F_CB1 : F_CA1;
    if (!(mode < C2_HSK && mode[0])) m |= p ? F_CB2 : F_CA2;
    drop_flags(m);
  endtask

  task automatic hsk_strobe(int p);
    if (c2_mode(p) == C2_HSK || c2_mode(p) == C2_PULSE) c2_lvl[p] = 1'b0;
  endtask

  task automatic bus_read(logic [3:0] a, output logic [7:0] q);
    logic [7:0] d;
    d = 0;
    case (a)
      R_ORB: begin
        d = acr[1] ? irx[1] : pb_level();
        drop_port_flags(1);
      end
      R_ORA, R_ORA_NH: begin
        d = acr[0] ? irx[0] : pin_level(0);
        if (a == R_ORA) begin
          drop_port_flags(0);
          hsk_strobe(0);
        end
      end
      R_DDRB: d = ddr[1];
      R_DDRA: d = ddr[0];
      R_T1CL: begin d = t1_cnt[7:0]; drop_flags(F_T1); end
      R_T1CH: d = t1_cnt[15:8];
      R_T1LL: d = t1_latch[7:0];
      R_T1LH: d = t1_latch[15:8];
      R_T2CL: begin d = t2_cnt[7:0]; drop_flags(F_T2); end
      R_T2CH: d = t2_cnt[15:8];
      R_SR: begin d = sr_byte; drop_flags(F_SR); end
      R_ACR: d = acr;
      R_PCR: d = pcr;
      R_IFR: d = ifr;
      default: d = {1'b1, ier[6:0]};
    endcase
    irq_refresh();
    q = d;
  endtask

  task automatic bus_write(logic [3:0] a, logic [7:0] d);
    logic [2:0] mode;
    case (a)
      R_ORB: begin orx[1] = d; drop_port_flags(1); hsk_strobe(1); end
      R_ORA: begin orx[0] = d; drop_port_flags(0); hsk_strobe(0); end
      R_DDRB: ddr[1] = d;
      R_DDRA: ddr[0] = d;
      R_T1CL, R_T1LL: t1_latch[7:0] = d;
      R_T1CH: begin
        t1_latch[15:8] = d;
        t1_cnt = t1_latch;
        if (!acr[7]) t1_tog = 0;
        drop_flags(F_T1);
        t1_pipe = {t1_pipe[15:8], 8'h04};
      end
      R_T1LH: begin t1_latch[15:8] = d; drop_flags(F_T1); end
      R_T2CL: t2_latch[7:0] = d;
      R_T2CH: begin
        t2_latch[15:8] = d;
        t2_cnt = t2_latch;
        t2_done = 0;
        drop_flags(F_T2);
        t2_pipe = 8'h04;
      end
      R_SR: begin sr_byte = d; drop_flags(F_SR); end
      R_ACR: begin acr = d; if (!d[5]) t2_pipe[0] = 0; end
      R_PCR: begin
        pcr = d;
        for (int p = 0; p < 2; p++) begin
          mode = c2_mode(p);
          if (mode >= C2_LOW) c2_lvl[p] = mode[0];
        end
      end
      R_IFR: drop_flags(d[7] ? 8'h7f : d);
      R_IER: ier = d[7] ? (ier | {1'b0, d[6:0]}) : (ier & ~{1'b0, d[6:0]});
      default: orx[0] = d;
    endcase
    irq_refresh();
  endtask

  task automatic clock_tick();
    logic pb6, fall;
    logic [7:0] pbl;
    for (int p = 0; p < 2; p++)
      if (c2_mode(p) == C2_PULSE) c2_lvl[p] = 1'b1;
    if (edges[0]) begin ifr |= F_CA1; if (c2_mode(0) == C2_HSK) c2_lvl[0] = 1; end
    if (edges[1] && c2_is_input(0)) ifr |= F_CA2;
    if (edges[2]) begin ifr |= F_CB1; if (c2_mode(1) == C2_HSK) c2_lvl[1] = 1; end
    if (edges[3] && c2_is_input(1)) ifr |= F_CB2;
    edges = 0;
    pbl = pb_level();
    pb6 = pbl[6];
    fall = last_pb6 && !pb6;
    last_pb6 = pb6;
    if (t1_pipe[0]) t1_cnt--;
    if (t1_cnt == 16'hffff) begin
      if (acr[6]) begin t1_tog ^= 1; ifr |= F_T1; end
      else if (!t1_tog) begin ifr |= F_T1; t1_tog = 1; end
      t1_pipe |= 16'h0200;
    end
    if (t1_pipe[8]) t1_cnt = t1_latch;
    if (acr[5]) begin
      if (fall) t2_cnt--;
    end else if (t2_pipe[0]) t2_cnt--;
    if (t2_cnt == 16'hffff && !t2_done) begin ifr |= F_T2; t2_done = 1; end
    if (irq_dly[0]) begin ifr |= F_ANY; irq_now = 1; end
    t1_pipe |= 16'h0004;
    t2_pipe |= 8'h04;
    if (ifr & ier & 8'h7f) irq_dly |= 8'h02;
    t1_pipe = (t1_pipe >> 1) & 16'h7f7f;
    t2_pipe = (t2_pipe >> 1) & 8'h7f;
    irq_dly = (irq_dly >> 1) & 8'h7f;
    irq_refresh();
  endtask

  task automatic sense_line(int b, logic now, bit is_c2, int p);
    logic prev, rise;
    logic [2:0] mode;
    prev = lines[b];
    lines[b] = now;
    mode = c2_mode(p);
    if (is_c2) begin
      if (!c2_is_input(p)) return;
      rise = mode[1];
    end else rise = p ? pcr[4] : pcr[0];
    edges[b] = (prev != now) && (now == rise);
  endtask

  task automatic model_request(logic [1:0] op, logic [31:0] d);
    via_result_t r;
    r.rd = 0;
    case (via_op_t'(op))
      OP_READ:  bus_read(d[3:0], r.rd);
      OP_WRITE: bus_write(d[3:0], d[11:4]);
      OP_TICK:  clock_tick();
      default: begin
        irx[0] = (irx[0] & ddr[0]) | (d[19:12] & ~ddr[0]);
        irx[1] = (irx[1] & ddr[1]) | (d[27:20] & ~ddr[1]);
        sense_line(0, d[28], 0, 0);
        sense_line(1, d[29], 1, 0);
        sense_line(2, d[30], 0, 1);
        sense_line(3, d[31], 1, 1);
      end
    endcase
    r.irq = irq_now;
    r.pa = pin_level(0);
    r.pb = pb_level();
    r.ca2 = c2_lvl[0];
    r.cb2 = c2_lvl[1];
    result_q.push_back(r);
  endtask

  task automatic report(string what, logic [7:0] want, logic [7:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    via_result_t want, got;
    if (!rst_n) begin
      t1_cnt = 0; t1_latch = 16'hffff; t2_cnt = 0; t2_latch = 16'hffff;
      t1_pipe = 0; t2_pipe = 0; t1_tog = 0; t2_done = 0;
      ifr = 0; ier = 0; acr = 0; pcr = 0; sr_byte = 0;
      orx = '{0, 0}; ddr = '{0, 0}; irx = '{8'hff, 8'hff};
      lines = 0; edges = 0; c2_lvl = 2'b11; irq_now = 0; irq_dly = 0; last_pb6 = 1;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (in_tvalid && in_tready) model_request(in_tuser, in_tdata);
      // predictions for this edge's request are in before the result is taken;
      // the same edge's result must still pass the input and result registers, so it is never here yet
      if (out_tvalid && out_tready) begin
        got = out_tdata[26:0];
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: result with none expected", $realtime);
        end else begin
          want = result_q.pop_front();
          if (out_tdata[0 +: 8] === 'x || got !== want) begin
            if (got.rd !== want.rd) report("read_data", want.rd, got.rd);
            if (got.irq !== want.irq) report("irq_level", want.irq, got.irq);
            if (got.pa !== want.pa) report("port_a_out", want.pa, got.pa);
            if (got.pb !== want.pb) report("port_b_out", want.pb, got.pb);
            if (got.ca2 !== want.ca2) report("ca2_level_out", want.ca2, got.ca2);
            if (got.cb2 !== want.cb2) report("cb2_level_out", want.cb2, got.cb2);
          end
        end
      end
    end
    pending_count = result_q.size();
  end

endmodule

// ----- verif/versatile_interface_adapter_test.sv -----
`timescale 1ns / 100ps

// Drives register reads/writes, ticks and pin updates into the adapter with
// random gaps on both sides; the checker predicts and compares each result.
module versatile_interface_adapter_test
  import via_pkg::*;
();

  localparam int WATCHDOG = 2000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = 0;
  logic [1:0]  in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  int          fail_count, pending_count;
  int          idle_cycles = 0;
  bit          sink_quiet = 0;

  always #2 clk = ~clk;

  versatile_interface_adapter dut (.*);
  versatile_interface_adapter_check check (.*);

  // watchdog: cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("versatile_interface_adapter_test: FAIL");
      $finish;
    end
  end

  // result side: random stall per result, with stretches of none
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = sink_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk iff out_tvalid);
    end
  end

  int gap_max = 14;

  task automatic send(via_op_t op, logic [3:0] a, logic [7:0] wd,
                      logic [7:0] pa = 0, logic [7:0] pb = 0, logic [3:0] c = 0);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {c, pb, pa, wd, a};
    @(posedge clk iff in_tready);
  endtask

  task automatic rd(logic [3:0] a);
    send(OP_READ, a, 8'($urandom));
  endtask

  task automatic wr(logic [3:0] a, logic [7:0] d);
    send(OP_WRITE, a, d);
  endtask

  task automatic tick();
    send(OP_TICK, 4'($urandom), 8'($urandom));
  endtask

  task automatic pins(logic [7:0] pa, logic [7:0] pb, logic [3:0] c);
    send(OP_PINS, 4'($urandom), 8'($urandom), pa, pb, c);
  endtask

  // timer 1 and 2 start, IRQ enable, a few ticks, flag reads
  task automatic timer_run();
    wr(R_ACR, 8'($urandom));
    wr(R_IER, 8'h80 | 8'($urandom));
    wr(R_T1LL, 8'($urandom_range(0, 3)));
    wr(R_T1CH, 8'd0);
    wr(R_T2CL, 8'($urandom_range(0, 3)));
    wr(R_T2CH, 8'd0);
    repeat ($urandom_range(2, 9)) tick();
    rd(R_IFR);
    rd($urandom_range(0, 1) ? R_T1CL : R_T2CL);
  endtask

  // control-line handshake: pin edge, tick, port access
  task automatic line_run();
    wr(R_PCR, 8'($urandom));
    wr(R_IER, 8'h80 | 8'($urandom));
    pins(8'($urandom), 8'($urandom), 4'h0);
    pins(8'($urandom), 8'($urandom), 4'hf);
    tick();
    rd(R_IFR);
    if ($urandom_range(0, 1)) rd(R_ORA); else wr(R_ORB, 8'($urandom));
    tick();
    rd($urandom_range(0, 1) ? R_ORA_NH : R_ORB);
  endtask

  initial begin
    int sent;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: every register read at reset, extremes, every op
    for (int a = 0; a < 16; a++) rd(4'(a));
    wr(R_DDRA, 8'h0f);
    wr(R_DDRB, 8'hf0);
    pins(8'hff, 8'h00, 4'hf);
    pins(8'h00, 8'hff, 4'h0);
    wr(R_ORA, 8'hff);
    wr(R_ORB, 8'h00);
    wr(R_PCR, 8'hee);
    wr(R_PCR, 8'hcc);
    wr(R_IFR, 8'hff);
    wr(R_IER, 8'hff);
    wr(R_IER, 8'h7f);
    wr(R_SR, 8'ha5);
    tick();
    sent = 29;

    // random: mostly well-formed timer and handshake sequences
    while (sent < 950) begin
      gap_max = ($urandom_range(0, 4) == 0) ? 0 : 14;
      sink_quiet = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 5))
        0, 1: begin timer_run(); sent += 12; end
        2, 3: begin line_run(); sent += 9; end
        default: begin
          repeat (8) begin
            send(via_op_t'($urandom_range(0, 3)), 4'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), 4'($urandom));
          end
          sent += 8;
        end
      endcase
    end
    in_tvalid <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("versatile_interface_adapter_test: PASS");
    else $display("versatile_interface_adapter_test: FAIL");
    $finish;
  end

endmodule
